// ===== hw/rtl/kbu_pkg.sv =====
// kbu_pkg: shared types and constants for the key event to UTF-8 byte encoder.
// No dependencies; imported by kbu_front, kbu_queue, kbu_back and the top level.
`default_nettype none

package kbu_pkg;

  // Virtual key codes that map to fixed bytes
  localparam logic [7:0] KEY_BACK  = 8'h08;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_RET   = 8'h0D;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_LEFT  = 8'h25;
  localparam logic [7:0] KEY_UP    = 8'h26;
  localparam logic [7:0] KEY_RIGHT = 8'h27;
  localparam logic [7:0] KEY_DOWN  = 8'h28;

  // Bytes produced by the mapped keys
  localparam logic [7:0] BYTE_UP    = 8'h41;  // 'A'
  localparam logic [7:0] BYTE_DOWN  = 8'h42;  // 'B'
  localparam logic [7:0] BYTE_RIGHT = 8'h43;  // 'C'
  localparam logic [7:0] BYTE_LEFT  = 8'h44;  // 'D'
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_RET   = 8'd13;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_BACK  = 8'd127;

  // UTF-16 surrogate ranges
  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;

  // Code point limits for the UTF-8 length classes
  localparam logic [20:0] CP_LIM1    = 21'h00080;
  localparam logic [20:0] CP_LIM2    = 21'h00800;
  localparam logic [20:0] CP_LIM3    = 21'h10000;
  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One event's output: up to four bytes, first in slot 0, and the index of the last one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } kbu_rec_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } kbu_qstat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kbu_front.sv =====
// kbu_front: accepts key events, tracks the held high surrogate and builds the byte record.
// Depends on kbu_pkg; pushes records into kbu_queue.
`default_nettype none

module kbu_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             is_key_event_i,
  input  wire logic             key_down_i,
  input  wire logic [7:0]       virtual_key_i,
  input  wire logic [15:0]      code_unit_i,
  input  wire kbu_pkg::kbu_qstat_t qstat_i,
  output logic                  push_o,
  output kbu_pkg::kbu_rec_t     rec_o
);
  import kbu_pkg::*;

  logic        held_vld_q, held_vld_d;
  logic [9:0]  held_q, held_d;
  logic        accept, press, mapped, is_hi, is_lo, unit_nz;
  logic [7:0]  map_byte;
  logic [20:0] cp;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign press      = is_key_event_i && key_down_i;
  assign unit_nz    = code_unit_i != 16'h0000;

  // Decode the keys with fixed bytes
  always_comb begin
    mapped   = 1'b1;
    map_byte = 8'h00;
    case (virtual_key_i)
      KEY_UP:    map_byte = BYTE_UP;
      KEY_DOWN:  map_byte = BYTE_DOWN;
      KEY_RIGHT: map_byte = BYTE_RIGHT;
      KEY_LEFT:  map_byte = BYTE_LEFT;
      KEY_ESC:   map_byte = BYTE_ESC;
      KEY_RET:   map_byte = BYTE_RET;
      KEY_TAB:   map_byte = BYTE_TAB;
      KEY_BACK:  map_byte = BYTE_BACK;
      default:   mapped   = 1'b0;
    endcase
  end

  // Classify the code unit
  always_comb begin
    is_hi = code_unit_i inside {[HI_FIRST:HI_LAST]};
    is_lo = code_unit_i inside {[LO_FIRST:LO_LAST]};
  end

  // Form the code point: a surrogate pair or the unit itself
  always_comb begin
    if (is_lo) begin
      cp = CP_SUPP_BASE + {1'b0, held_q, code_unit_i[9:0]};
    end else begin
      cp = {5'b0_0000, code_unit_i};
    end
  end

  // Emit a record for a mapped key, a plain unit or a completed pair
  assign push_o = accept && press &&
                  (mapped || (unit_nz && !is_hi && (!is_lo || held_vld_q)));

  // Build the UTF-8 bytes
  always_comb begin
    rec_o = '0;
    if (mapped) begin
      rec_o.bytes[0] = map_byte;
      rec_o.last_idx = 2'd0;
    end else if (cp < CP_LIM1) begin
      rec_o.bytes[0] = cp[7:0];
      rec_o.last_idx = 2'd0;
    end else if (cp < CP_LIM2) begin
      rec_o.bytes[0] = {3'b110, cp[10:6]};
      rec_o.bytes[1] = {2'b10, cp[5:0]};
      rec_o.last_idx = 2'd1;
    end else if (cp < CP_LIM3) begin
      rec_o.bytes[0] = {4'b1110, cp[15:12]};
      rec_o.bytes[1] = {2'b10, cp[11:6]};
      rec_o.bytes[2] = {2'b10, cp[5:0]};
      rec_o.last_idx = 2'd2;
    end else begin
      rec_o.bytes[0] = {5'b11110, cp[20:18]};
      rec_o.bytes[1] = {2'b10, cp[17:12]};
      rec_o.bytes[2] = {2'b10, cp[11:6]};
      rec_o.bytes[3] = {2'b10, cp[5:0]};
      rec_o.last_idx = 2'd3;
    end
  end

  // Hold a high surrogate; drop it on any other nonzero unit of an unmapped key press
  always_comb begin
    held_vld_d = held_vld_q;
    held_d     = held_q;
    if (accept && press && !mapped && unit_nz) begin
      if (is_hi) begin
        held_vld_d = 1'b1;
        held_d     = code_unit_i[9:0];
      end else begin
        held_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= 1'b0;
    end else begin
      held_vld_q <= held_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kbu_queue.sv =====
// kbu_queue: short FIFO of byte records between the front and the back.
// Depends on kbu_pkg.
`default_nettype none

module kbu_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire kbu_pkg::kbu_rec_t  rec_i,
  input  wire logic               pop_i,
  output kbu_pkg::kbu_rec_t       rec_o,
  output kbu_pkg::kbu_qstat_t     qstat_o
);
  import kbu_pkg::*;

  kbu_rec_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign qstat_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign rec_o         = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kbu_back.sv =====
// kbu_back: takes records from the queue and sends their bytes one beat at a time.
// Depends on kbu_pkg; reads kbu_queue.
`default_nettype none

module kbu_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kbu_pkg::kbu_rec_t   rec_i,
  input  wire kbu_pkg::kbu_qstat_t qstat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     last_byte_o
);
  import kbu_pkg::*;

  logic            cur_vld_q, cur_vld_d;
  logic [3:0][7:0] cur_bytes_q, cur_bytes_d;
  logic [1:0]      cur_left_q, cur_left_d;
  logic            out_vld_q, out_vld_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;
  logic            slot_free, emit, cur_done;

  assign slot_free = !out_vld_q || out_ready_i;
  assign emit      = cur_vld_q && slot_free;
  assign cur_done  = !cur_vld_q || (emit && cur_left_q == 2'd0);
  assign pop_o     = cur_done && !qstat_i.empty;

  // Load a new record or shift out the current byte
  always_comb begin
    cur_vld_d   = cur_vld_q;
    cur_bytes_d = cur_bytes_q;
    cur_left_d  = cur_left_q;
    if (pop_o) begin
      cur_vld_d   = 1'b1;
      cur_bytes_d = rec_i.bytes;
      cur_left_d  = rec_i.last_idx;
    end else if (emit) begin
      cur_vld_d   = cur_left_q != 2'd0;
      cur_bytes_d = {8'h00, cur_bytes_q[3:1]};
      cur_left_d  = cur_left_q - 1'b1;
    end
  end

  // Output register: fill on emit, drop once taken
  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_byte_d = cur_bytes_q[0];
      out_last_d = cur_left_q == 2'd0;
    end else if (out_ready_i) begin
      out_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_bytes_q <= cur_bytes_d;
    cur_left_q  <= cur_left_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/key_event_to_utf8_bytes_top.sv =====
// key_event_to_utf8_bytes_top: key event to UTF-8 byte stream encoder.
// Depends on kbu_pkg, kbu_front, kbu_queue and kbu_back.
//
//   Channel | Handshake              | Beat carries
//   --------+------------------------+------------------------------------------------
//   in      | in_valid_i / in_ready_o  | is_key_event_i, key_down_i, virtual_key_i, code_unit_i
//   out     | out_valid_o / out_ready_i| out_byte_o, last_byte_o
//
// An event is accepted whenever the two-entry record queue has room;
// its first byte passes through the queue, the current record and the output register.
// The back sends one byte per cycle while out_ready_i is high, so an event costs
// one to four bytes of output bandwidth; the byte serializer sets the sustained rate.
// Events that produce no bytes are accepted and give nothing on out.
// Reset clears the held surrogate, the queue and the output register.
// A stall on out fills the queue and then drops in_ready_o.
`default_nettype none

module key_event_to_utf8_bytes_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        is_key_event_i,
  input  wire logic        key_down_i,
  input  wire logic [7:0]  virtual_key_i,
  input  wire logic [15:0] code_unit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_byte_o
);
  import kbu_pkg::*;

  kbu_rec_t   push_rec, pop_rec;
  kbu_qstat_t qstat;
  logic       push, pop;

  kbu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .is_key_event_i (is_key_event_i),
    .key_down_i     (key_down_i),
    .virtual_key_i  (virtual_key_i),
    .code_unit_i    (code_unit_i),
    .qstat_i        (qstat),
    .push_o         (push),
    .rec_o          (push_rec)
  );

  kbu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (pop_rec),
    .qstat_o (qstat)
  );

  kbu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (pop_rec),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/kbu_checker.sv =====
// kbu_checker: port-level assertions on the encoder's output byte stream.
// Depends only on the top level's ports; bound to key_event_to_utf8_bytes_top below.
`default_nettype none

module kbu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_byte_o
);

  logic [1:0] run_q, run_d;
  logic       out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  // Count bytes already sent for the current event
  always_comb begin
    run_d = run_q;
    if (out_beat) begin
      run_d = last_byte_o ? 2'd0 : run_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 2'd0;
    end else begin
      run_q <= run_d;
    end
  end

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_byte_o))
    else $error("output beat changed while stalled");

  // No event gives more than four bytes
  a_max_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && run_q == 2'd3 |-> last_byte_o)
    else $error("event produced more than four bytes");

  // An event never opens with a continuation byte
  a_first_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && run_q == 2'd0 |-> out_byte_o[7:6] != 2'b10)
    else $error("first byte of an event is a continuation byte");

  // Every later byte is a continuation byte
  a_rest_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && run_q != 2'd0 |-> out_byte_o[7:6] == 2'b10)
    else $error("non-first byte is not a continuation byte");

  // A multi-byte lead is never the last byte
  a_lead_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_byte_o[7:6] == 2'b11 |-> !last_byte_o)
    else $error("lead byte marked as last");

endmodule

bind key_event_to_utf8_bytes_top kbu_checker u_kbu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_byte_o (last_byte_o)
);

`default_nettype wire
